/* rtl/weighted_histogram_running_stats_macros.svh */
// Assertion macros used by the histogram back end.
`ifndef WEIGHTED_HISTOGRAM_RUNNING_STATS_MACROS_SVH
`define WEIGHTED_HISTOGRAM_RUNNING_STATS_MACROS_SVH

// same-cycle implication
`define WHRS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WHRS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/whrs_pkg.sv */
// Shared types, constants and divider step for the weighted histogram.
`default_nettype none
package whrs_pkg;
	localparam int NUM_BINS_DEF = 256;
	localparam int FIFO_DEPTH   = 4;
	localparam int DIV_ITERS    = 40;   // two quotient bits per cycle, 80-bit numerator
	localparam int NUM_W        = 2 * DIV_ITERS;

	localparam logic REG_INV_BIN_WIDTH = 1'b0;
	localparam logic REG_BASE_BIN      = 1'b1;

	localparam logic [31:0] INV_BIN_WIDTH_RST = 32'd65536;
	localparam logic [31:0] BASE_BIN_RST      = 32'hFFFF_FF80;

	typedef struct packed {
		logic [31:0] mean;
		logic [62:0] mean_square;
		logic [39:0] total_weight;
		logic [7:0]  slot;
		logic [31:0] slot_weight;
		logic [7:0]  mode_slot;
		logic [7:0]  lowest_slot;
		logic [7:0]  highest_slot;
		logic        out_of_range;
		logic        ignored;
	} res_t;

	typedef struct packed {
		logic [41:0] rem;
		logic        q;
	} dstep_t;

	function automatic dstep_t div_step(input logic [41:0] rem, input logic b,
	                                    input logic [40:0] d);
		dstep_t      r;
		logic [41:0] t;
		t = {rem[40:0], b};
		if (t >= {1'b0, d}) begin
			r.rem = t - {1'b0, d};
			r.q   = 1'b1;
		end else begin
			r.rem = t;
			r.q   = 1'b0;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/whrs_front.sv */
// Front end: config registers, bin multiply and slot classification.
`default_nettype none
module whrs_front import whrs_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int IW       = $clog2(NUM_BINS),
	parameter int ITEM_W   = 50 + IW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [31:0]       wr_data,
	input  wire logic              push,
	output logic                   full,
	input  wire logic signed [31:0] sample_value,
	input  wire logic [15:0]       sample_weight,
	input  wire logic              hold,
	output logic                   q_push,
	input  wire logic              q_full,
	output logic [ITEM_W-1:0]      q_data
);
	logic [31:0]        ibw_q, base_q;
	logic               v_s1, v_s2;
	logic signed [31:0] x_s1, x_s2;
	logic [15:0]        w_s1, w_s2;
	logic [63:0]        prod_s2;
	logic               adv2, acc;
	logic [31:0]        ax1;
	logic [33:0]        bin, slot;
	logic               inr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibw_q  <= INV_BIN_WIDTH_RST;
			base_q <= BASE_BIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INV_BIN_WIDTH: ibw_q  <= wr_data;
				REG_BASE_BIN:      base_q <= wr_data;
				default:           ;
			endcase
		end
	end

	assign adv2   = !v_s2 || !q_full;
	assign full   = hold || (v_s1 && !adv2);
	assign acc    = push && !full;
	assign q_push = v_s2 && !q_full;
	assign ax1    = x_s1[31] ? 32'(-x_s1) : 32'(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc)
				v_s1 <= 1'b1;
			else if (adv2)
				v_s1 <= 1'b0;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1 <= sample_value;
			w_s1 <= sample_weight;
		end
		if (adv2 && v_s1) begin
			x_s2    <= x_s1;
			w_s2    <= w_s1;
			prod_s2 <= ax1 * ibw_q;
		end
	end

	always_comb begin
		bin = x_s2[31] ? 34'(-{2'b00, prod_s2[63:32]}) : {2'b00, prod_s2[63:32]};
		slot = bin - {{2{base_q[31]}}, base_q};
		inr  = !slot[33] && (slot < 34'(NUM_BINS));
	end

	assign q_data = {x_s2, w_s2, slot[IW-1:0], !inr, (w_s2 == 16'd0)};
endmodule
`default_nettype wire

/* rtl/whrs_fifo.sv */
// Small queue between front and back.
`default_nettype none
module whrs_fifo import whrs_pkg::*; #(
	parameter int W = 58
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	output logic              fl,
	input  wire logic         rd,
	output logic [W-1:0]      rdata,
	output logic              em
);
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]  mem_q [FIFO_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign fl    = (cnt_q == CW'(FIFO_DEPTH));
	assign em    = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !fl)
				wp_q <= PW'(wp_q + 1'b1);
			if (rd && !em)
				rp_q <= PW'(rp_q + 1'b1);
			cnt_q <= CW'(cnt_q + CW'(wr && !fl) - CW'(rd && !em));
		end
	end

	always_ff @(posedge clk)
		if (wr && !fl)
			mem_q[wp_q] <= wdata;
endmodule
`default_nettype wire

/* rtl/whrs_back.sv */
// Back end: slot store, running statistics with iterative divider, result register.
`default_nettype none
`include "weighted_histogram_running_stats_macros.svh"
module whrs_back import whrs_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF,
	parameter int IW       = $clog2(NUM_BINS),
	parameter int ITEM_W   = 50 + IW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire logic [ITEM_W-1:0] q_data,
	output logic                   q_pop,
	output logic                   clearing,
	output res_t                   res,
	output logic                   empty,
	input  wire logic              pop
);
	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_LOAD  = 8'b0000_0100,
		ST_DIFF  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_DINIT = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_UPD   = 8'b1000_0000
	} st_t;

	localparam int DCW = $clog2(DIV_ITERS);

	st_t st_q;
	logic [31:0]        mem [NUM_BINS];
	logic [31:0]        rd_q;
	logic signed [31:0] x_q;
	logic [15:0]        w_q;
	logic [IW-1:0]      idx_q, clr_q;
	logic               oor_q, ign_q;

	logic [39:0]        ws_q;
	logic signed [31:0] mean_q;
	logic [62:0]        ms_q;
	logic [IW-1:0]      mode_q, lo_q, hi_q;
	logic [31:0]        mode_w_q;
	logic               has_q;

	logic [62:0] sq_q;
	logic        mneg_q, msneg_q;
	logic [32:0] mmag_q;
	logic [62:0] msmag_q;
	logic [40:0] den_q;
	logic [31:0] nsw_q;
	logic [48:0] pm_q;
	logic [47:0] pl_q;
	logic [46:0] ph_q;
	logic [NUM_W-1:0] nm_q, ns_q;
	logic [41:0]      rm_q, rs_q;
	logic [32:0]      qm_q;
	logic [62:0]      qs_q;
	logic [DCW-1:0]   cnt_q;
	logic             ov_q;
	res_t             out_q;

	logic [31:0] ax;
	logic [32:0] md;
	logic [32:0] nsw_sum;
	dstep_t      m1, m2, s1, s2;
	logic        upd_go, mem_we, first, hist;
	logic [IW-1:0] mem_wa;
	logic [31:0] mem_wd;
	logic signed [31:0] mean_n;
	logic [62:0] ms_n;
	logic [39:0] ws_n;
	logic [IW-1:0] mode_n, lo_n, hi_n;
	logic [31:0] mode_w_n;

	assign q_pop    = (st_q == ST_IDLE) && !q_empty;
	assign clearing = (st_q == ST_CLR);
	assign upd_go   = (st_q == ST_UPD) && (!ov_q || pop);
	assign empty    = !ov_q;
	assign res      = out_q;
	assign hist     = !ign_q && !oor_q;

	assign ax      = x_q[31] ? 32'(-x_q) : 32'(x_q);
	assign md      = {x_q[31], x_q} - {mean_q[31], mean_q};
	assign nsw_sum = {1'b0, rd_q} + 33'(w_q);

	assign m1 = div_step(rm_q, nm_q[NUM_W-1], den_q);
	assign m2 = div_step(m1.rem, nm_q[NUM_W-2], den_q);
	assign s1 = div_step(rs_q, ns_q[NUM_W-1], den_q);
	assign s2 = div_step(s1.rem, ns_q[NUM_W-2], den_q);

	assign mem_we = clearing || (upd_go && hist);
	assign mem_wa = clearing ? clr_q : idx_q;
	assign mem_wd = clearing ? 32'd0 : nsw_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[idx_q];
	end

	always_comb begin
		first    = (ws_q == 40'd0);
		mean_n   = mean_q;
		ms_n     = ms_q;
		ws_n     = ws_q;
		mode_n   = mode_q;
		mode_w_n = mode_w_q;
		lo_n     = lo_q;
		hi_n     = hi_q;
		if (!ign_q) begin
			if (first) begin
				mean_n = x_q;
				ms_n   = sq_q;
				ws_n   = 40'(w_q);
			end else begin
				mean_n = mneg_q ? mean_q - qm_q[31:0] : mean_q + qm_q[31:0];
				ms_n   = msneg_q ? ms_q - qs_q : ms_q + qs_q;
				ws_n   = den_q[40] ? '1 : den_q[39:0];
			end
		end
		if (hist) begin
			if (nsw_q > mode_w_q) begin
				mode_w_n = nsw_q;
				mode_n   = idx_q;
			end
			if (!has_q) begin
				lo_n = idx_q;
				hi_n = idx_q;
			end else begin
				if (idx_q < lo_q)
					lo_n = idx_q;
				if (idx_q > hi_q)
					hi_n = idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLR;
			clr_q    <= '0;
			cnt_q    <= '0;
			ov_q     <= 1'b0;
			ws_q     <= '0;
			mean_q   <= '0;
			ms_q     <= '0;
			mode_q   <= '0;
			mode_w_q <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			has_q    <= 1'b0;
		end else begin
			if (upd_go)
				ov_q <= 1'b1;
			else if (pop)
				ov_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= IW'(clr_q + 1'b1);
					if (clr_q == IW'(NUM_BINS - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (!q_empty)
						st_q <= q_data[0] ? ST_UPD : ST_LOAD;
				end
				ST_LOAD:  st_q <= ST_DIFF;
				ST_DIFF:  st_q <= ST_MUL;
				ST_MUL:   st_q <= ST_DINIT;
				ST_DINIT: begin
					cnt_q <= '0;
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= DCW'(cnt_q + 1'b1);
					if (cnt_q == DCW'(DIV_ITERS - 1))
						st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						st_q     <= ST_IDLE;
						ws_q     <= ws_n;
						mean_q   <= mean_n;
						ms_q     <= ms_n;
						mode_q   <= mode_n;
						mode_w_q <= mode_w_n;
						lo_q     <= lo_n;
						hi_q     <= hi_n;
						if (hist)
							has_q <= 1'b1;
					end
				end
				default: st_q <= ST_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			{x_q, w_q, idx_q, oor_q, ign_q} <= q_data;
		if (st_q == ST_LOAD) begin
			sq_q   <= 63'(ax * ax);
			mneg_q <= md[32];
			mmag_q <= md[32] ? 33'(-md) : md;
			den_q  <= {1'b0, ws_q} + 41'(w_q);
		end
		if (st_q == ST_DIFF) begin
			msneg_q <= (sq_q < ms_q);
			msmag_q <= (sq_q < ms_q) ? ms_q - sq_q : sq_q - ms_q;
			nsw_q   <= nsw_sum[32] ? '1 : nsw_sum[31:0];
		end
		if (st_q == ST_MUL) begin
			pm_q <= mmag_q * w_q;
			pl_q <= msmag_q[31:0] * w_q;
			ph_q <= msmag_q[62:32] * w_q;
		end
		if (st_q == ST_DINIT) begin
			nm_q <= NUM_W'(pm_q);
			ns_q <= NUM_W'({31'd0, pl_q}) + NUM_W'({ph_q, 32'd0});
			rm_q <= '0;
			rs_q <= '0;
			qm_q <= '0;
			qs_q <= '0;
		end
		if (st_q == ST_DIV) begin
			nm_q <= {nm_q[NUM_W-3:0], 2'b00};
			ns_q <= {ns_q[NUM_W-3:0], 2'b00};
			rm_q <= m2.rem;
			rs_q <= s2.rem;
			qm_q <= {qm_q[30:0], m1.q, m2.q};
			qs_q <= {qs_q[60:0], s1.q, s2.q};
		end
		if (upd_go) begin
			out_q.mean         <= mean_n;
			out_q.mean_square  <= ms_n;
			out_q.total_weight <= ws_n;
			out_q.slot         <= hist ? 8'(idx_q) : 8'd0;
			out_q.slot_weight  <= hist ? nsw_q : 32'd0;
			out_q.mode_slot    <= 8'(mode_n);
			out_q.lowest_slot  <= 8'(lo_n);
			out_q.highest_slot <= 8'(hi_n);
			out_q.out_of_range <= oor_q && !ign_q;
			out_q.ignored      <= ign_q;
		end
	end

	`WHRS_ASSERT_IMP(a_div_cnt, clk, arst_n, (st_q == ST_DIV), (cnt_q <= DCW'(DIV_ITERS - 1)), "divider count overrun")
	`WHRS_ASSERT_IMP(a_no_pop_clr, clk, arst_n, (st_q == ST_CLR), (!q_pop && !ov_q), "request taken during clear")
	`WHRS_ASSERT_NXT(a_mode_max, clk, arst_n, upd_go && hist, (out_q.slot_weight <= mode_w_q), "mode weight below slot weight")
endmodule
`default_nettype wire

/* rtl/weighted_histogram_running_stats.sv */
// Top level: weighted histogram with running mean and mean-square.
//  channel   | handshake        | payload
//  config    | wr_en            | wr_index, wr_data
//  input     | push / full      | sample_value, sample_weight
//  result    | empty / pop      | mean .. ignored
// A weighted request passes through the back-end states LOAD, DIFF, MUL, DINIT,
// DIV and UPD; the radix-4 divider forms (value - mean) * w / (S + w).
// A zero-weight request goes from IDLE straight to UPD. The front end and a 4-entry queue
// keep taking requests while the back end divides.
// After reset, full stays high while the slot store clears.
`default_nettype none
module weighted_histogram_running_stats import whrs_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic               wr_index,
	input  wire logic [31:0]        wr_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] sample_value,
	input  wire logic [15:0]        sample_weight,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      mean,
	output logic [62:0]             mean_square,
	output logic [39:0]             total_weight,
	output logic [7:0]              slot,
	output logic [31:0]             slot_weight,
	output logic [7:0]              mode_slot,
	output logic [7:0]              lowest_slot,
	output logic [7:0]              highest_slot,
	output logic                    out_of_range,
	output logic                    ignored
);
	localparam int IW     = $clog2(NUM_BINS);
	localparam int ITEM_W = 50 + IW;

	logic              fq_push, fq_full, fq_empty, fq_pop, clearing;
	logic [ITEM_W-1:0] fq_wdata, fq_rdata;
	res_t              res;

	whrs_front #(.NUM_BINS(NUM_BINS), .IW(IW), .ITEM_W(ITEM_W)) u_front (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data, .push, .full,
		.sample_value, .sample_weight, .hold(clearing),
		.q_push(fq_push), .q_full(fq_full), .q_data(fq_wdata)
	);

	whrs_fifo #(.W(ITEM_W)) u_fifo (
		.clk, .arst_n, .wr(fq_push), .wdata(fq_wdata), .fl(fq_full),
		.rd(fq_pop), .rdata(fq_rdata), .em(fq_empty)
	);

	whrs_back #(.NUM_BINS(NUM_BINS), .IW(IW), .ITEM_W(ITEM_W)) u_back (
		.clk, .arst_n, .q_empty(fq_empty), .q_data(fq_rdata), .q_pop(fq_pop),
		.clearing, .res, .empty, .pop
	);

	assign mean         = res.mean;
	assign mean_square  = res.mean_square;
	assign total_weight = res.total_weight;
	assign slot         = res.slot;
	assign slot_weight  = res.slot_weight;
	assign mode_slot    = res.mode_slot;
	assign lowest_slot  = res.lowest_slot;
	assign highest_slot = res.highest_slot;
	assign out_of_range = res.out_of_range;
	assign ignored      = res.ignored;
endmodule
`default_nettype wire
